FILE: src/eva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eva_pkg
// Shared codes, constants and helpers of the eased value animator.
// ----------------------------------------------------------------------------
package eva_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic [15:0] SPRING_DEFAULT = 16'd768;
  localparam logic [15:0] REMAIN_MAX     = 16'hFFFF;

  // request kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_SHIFT  = 3'd2;
  localparam logic [2:0] KIND_ADJUST = 3'd3;
  localparam logic [2:0] KIND_PAUSE  = 3'd4;
  localparam logic [2:0] KIND_RESUME = 3'd5;

  // curve styles
  localparam logic [2:0] STYLE_LINEAR   = 3'd0;
  localparam logic [2:0] STYLE_IN       = 3'd1;
  localparam logic [2:0] STYLE_OUT      = 3'd2;
  localparam logic [2:0] STYLE_BOTH     = 3'd3;
  localparam logic [2:0] STYLE_BOUNCE   = 3'd4;
  localparam logic [2:0] STYLE_FBOUNCE  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STYLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING = 2'd1;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: src/eased_value_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_value_animator
// Animated Q16.16 value easing from start to target over a span of ticks.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   in      | in  | in_valid_i/in_ready_o  | kind, operand, span, delay
//   out     | out | out_valid_o/out_ready_i| current value, done, remaining
//   cfg     | in  | cfg_valid_i/cfg_ready_o| register index, write data
//
// One request at a time; in_ready_o is high only while the sequencer idles.
// Jump sets and requests that land at or past the end go from setup straight
// to the finish state. Quadratic curves use the serial divider forming t
// (NW = max(F+32, 49)) and the serial multiplier; linear skips the ease
// multiply and a clamped t skips the divide.
// Bounce style 4 adds two more divisions and the region step.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its final write waits for the slot to drain.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module eased_value_animator #(
  parameter int FRACTION_BITS = eva_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    kind_i,
  input  logic signed [31:0]            operand_value_i,
  input  logic [15:0]                   span_ticks_i,
  input  logic [15:0]                   delay_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            current_value_o,
  output logic                          done_res_o,
  output logic [15:0]                   remaining_ticks_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [eva_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [eva_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import eva_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int NW   = (F + 32 > 49) ? F + 32 : 49;  // divider dividend width
  localparam int DENW = 33;
  localparam int VW   = NW + 2;                       // delta / bounce terms
  localparam int RW   = VW + 4;                       // result accumulation
  localparam int TW   = F + 1;                        // t and curve factor
  localparam int BW   = F + 2;                        // multiplier B operand
  localparam int PW   = VW + BW;

  localparam logic [TW-1:0] ONE_T  = TW'(1) << F;
  localparam logic [TW-1:0] HALF_T = TW'(1) << (F - 1);
  localparam logic [BW-1:0] ONE_B  = BW'(1) << F;
  localparam logic [BW-1:0] TWO_B  = BW'(1) << (F + 1);
  localparam logic [BW-1:0] THR_B  = ONE_B + TWO_B;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_SETUP, S_TDIV, S_CURVE, S_BDIV1, S_BDIV2, S_REGION,
    S_EASE, S_EASE_W, S_SCALE, S_SCALE_W, S_FINISH
  } state_e;

  typedef enum logic [1:0] {CV_LIN, CV_IN, CV_OUT, CV_BOTH} curve_e;

  state_e state_q;

  // configuration
  logic [2:0]  style_q;
  logic [15:0] spring_q;

  // animation state
  logic [31:0] start_q, target_q, frame_q, set_q, end_q, paused_at_q;
  logic [15:0] delay_q;
  logic        paused_q;

  // captured request
  logic [2:0]  kind_q;
  logic [31:0] opv_q;
  logic [15:0] span_in_q, dly_in_q;

  // working registers
  logic signed [32:0]   delta_q;
  logic [TW-1:0]        t_q, u_q, f_q;
  logic signed [VW-1:0] b1_q, b2_q, x_q;
  logic signed [RW-1:0] base_q, res_q;
  logic                 neg_q, half_q, addh_q;
  curve_e               cv_q;
  logic [31:0]          sq_q;

  // shared units
  logic                 mul_start_q, mul_done;
  logic signed [VW-1:0] mul_a_q;
  logic [BW-1:0]        mul_b_q;
  logic signed [PW-1:0] mul_p;
  logic                 div_start_q, div_done;
  logic [NW-1:0]        div_num_q, div_quo;
  logic [DENW-1:0]      div_den_q;

  // output register
  logic                 out_valid_q, out_done_q;
  logic [31:0]          out_value_q;
  logic [15:0]          out_rem_q;

  eva_mul #(.AW(VW), .BW(BW)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  eva_div #(.NW(NW), .DW(DENW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start_q), .num_i(div_num_q), .den_i(div_den_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  // time bookkeeping
  logic [31:0]          now_w, span32_w, to_end_w, since_w, rem_w, fr_end_w;
  logic                 reach_w;
  logic signed [33:0]   spanm_w, el_w;
  logic [32:0]          dmag_w;
  logic [15:0]          spring_w;
  logic [TW+0:0]        t3_w;
  logic signed [VW-1:0] pd_w, sp_w, b12_w;
  logic signed [RW-1:0] s0_r, tg_r, sc_r;
  logic [BW-1:0]        u_b, u2_b;
  logic signed [32:0]   sh_start_w, sh_target_w;

  assign now_w    = paused_q ? paused_at_q : frame_q;
  assign span32_w = end_q - set_q;
  assign to_end_w = now_w - end_q;
  assign reach_w  = ~to_end_w[31];
  assign since_w  = now_w - set_q;
  assign rem_w    = end_q - now_w;
  assign fr_end_w = frame_q - end_q;
  assign spanm_w  = $signed({{2{span32_w[31]}}, span32_w}) - $signed({18'd0, delay_q});
  assign el_w     = $signed({{2{since_w[31]}}, since_w}) - $signed({18'd0, delay_q});
  assign dmag_w   = delta_q[32] ? 33'(-delta_q) : 33'(delta_q);
  assign spring_w = (spring_q == 16'd0) ? SPRING_DEFAULT : spring_q;
  assign t3_w     = {1'b0, t_q} + {t_q, 1'b0};
  assign pd_w     = VW'(delta_q) + b1_q;
  assign b12_w    = b1_q + b2_q;
  assign sp_w     = $signed(VW'(spring_w) << (F - 8));
  assign s0_r     = RW'($signed(start_q));
  assign tg_r     = RW'($signed(target_q));
  assign sc_r     = RW'(mul_p >>> F);
  assign u_b      = BW'(u_q);
  assign u2_b     = u_b << 1;
  assign sh_start_w  = $signed({start_q[31], start_q}) + $signed({opv_q[31], opv_q});
  assign sh_target_w = $signed({target_q[31], target_q}) + $signed({opv_q[31], opv_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      style_q     <= STYLE_LINEAR;
      spring_q    <= SPRING_DEFAULT;
      start_q     <= '0;
      target_q    <= '0;
      frame_q     <= '0;
      set_q       <= '0;
      end_q       <= '0;
      paused_at_q <= '0;
      delay_q     <= '0;
      paused_q    <= 1'b0;
      kind_q      <= KIND_TICK;
      opv_q       <= '0;
      span_in_q   <= '0;
      dly_in_q    <= '0;
      delta_q     <= '0;
      t_q         <= '0;
      u_q         <= '0;
      f_q         <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      x_q         <= '0;
      base_q      <= '0;
      res_q       <= '0;
      neg_q       <= 1'b0;
      half_q      <= 1'b0;
      addh_q      <= 1'b0;
      cv_q        <= CV_LIN;
      sq_q        <= '0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
      out_value_q <= '0;
      out_rem_q   <= '0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;

      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_STYLE) begin
          style_q <= cfg_data_i[2:0];
        end else if (cfg_index_i == CFG_SPRING) begin
          spring_q <= cfg_data_i;
        end
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q    <= kind_i;
            opv_q     <= operand_value_i;
            span_in_q <= span_ticks_i;
            dly_in_q  <= delay_ticks_i;
            state_q   <= S_APPLY;
          end
        end

        S_APPLY: begin
          // set and resume both leave the paused state first
          if ((kind_q == KIND_SET || kind_q == KIND_RESUME) && paused_q) begin
            paused_q <= 1'b0;
            set_q    <= set_q + (frame_q - paused_at_q);
            end_q    <= end_q + (frame_q - paused_at_q);
          end
          if (kind_q == KIND_TICK) begin
            frame_q <= frame_q + 32'd1;
          end
          if (kind_q == KIND_SHIFT) begin
            start_q  <= sat32(64'(sh_start_w));
            target_q <= sat32(64'(sh_target_w));
          end
          if (kind_q == KIND_ADJUST) begin
            target_q <= opv_q;
          end
          if (kind_q == KIND_PAUSE && !paused_q && fr_end_w[31]) begin
            paused_at_q <= frame_q;
            paused_q    <= 1'b1;
          end
          state_q <= S_SETUP;
        end

        S_SETUP: begin
          delta_q <= $signed({target_q[31], target_q}) - $signed({start_q[31], start_q});
          if (kind_q == KIND_SET && span_in_q == 16'd0) begin
            state_q <= S_FINISH;
          end else if (reach_w || span32_w[31] || span32_w == 32'd0) begin
            res_q   <= tg_r;
            state_q <= S_FINISH;
          end else if (spanm_w <= 34'sd0 || el_w <= 34'sd0) begin
            t_q     <= '0;
            state_q <= S_CURVE;
          end else if (el_w >= spanm_w) begin
            t_q     <= ONE_T;
            state_q <= S_CURVE;
          end else begin
            div_num_q   <= NW'(el_w[30:0]) << F;
            div_den_q   <= spanm_w[DENW-1:0];
            div_start_q <= 1'b1;
            state_q     <= S_TDIV;
          end
        end

        S_TDIV: begin
          if (div_done) begin
            t_q     <= TW'(div_quo);
            state_q <= S_CURVE;
          end
        end

        S_CURVE: begin
          base_q <= s0_r;
          x_q    <= VW'(delta_q);
          neg_q  <= 1'b0;
          u_q    <= t_q;
          state_q <= S_EASE;
          unique case (style_q)
            STYLE_IN:   cv_q <= CV_IN;
            STYLE_OUT:  cv_q <= CV_OUT;
            STYLE_BOTH: cv_q <= CV_BOTH;
            STYLE_BOUNCE: begin
              // overshoot delta/spring, undershoot delta/spring^2
              sq_q        <= 32'(spring_w) * 32'(spring_w);
              div_num_q   <= NW'(dmag_w) << 8;
              div_den_q   <= DENW'(spring_w);
              div_start_q <= 1'b1;
              state_q     <= S_BDIV1;
            end
            STYLE_FBOUNCE: begin
              b1_q    <= delta_q[32] ? -sp_w : sp_w;
              b2_q    <= delta_q[32] ? -(sp_w >>> 1) : (sp_w >>> 1);
              state_q <= S_REGION;
            end
            default: cv_q <= CV_LIN;
          endcase
        end

        S_BDIV1: begin
          if (div_done) begin
            b1_q        <= delta_q[32] ? -$signed(VW'(div_quo)) : $signed(VW'(div_quo));
            div_num_q   <= NW'(dmag_w) << 16;
            div_den_q   <= {1'b0, sq_q};
            div_start_q <= 1'b1;
            state_q     <= S_BDIV2;
          end
        end

        S_BDIV2: begin
          if (div_done) begin
            b2_q    <= delta_q[32] ? -$signed(VW'(div_quo)) : $signed(VW'(div_quo));
            state_q <= S_REGION;
          end
        end

        S_REGION: begin
          // thirds: rise to overshoot, fall to undershoot, settle on target
          priority if (t3_w < (TW + 1)'(ONE_T)) begin
            base_q <= s0_r;
            x_q    <= pd_w;
            neg_q  <= 1'b0;
            cv_q   <= CV_OUT;
            u_q    <= TW'(t3_w);
          end else if (t3_w < ((TW + 1)'(ONE_T) << 1)) begin
            base_q <= s0_r + RW'(pd_w);
            x_q    <= b12_w;
            neg_q  <= 1'b1;
            cv_q   <= CV_BOTH;
            u_q    <= TW'(t3_w - (TW + 1)'(ONE_T));
          end else begin
            base_q <= tg_r - RW'(b2_q);
            x_q    <= b2_q;
            neg_q  <= 1'b0;
            cv_q   <= CV_BOTH;
            u_q    <= TW'(t3_w - ((TW + 1)'(ONE_T) << 1));
          end
          state_q <= S_EASE;
        end

        S_EASE: begin
          half_q <= 1'b0;
          addh_q <= 1'b0;
          mul_a_q <= VW'(u_b);
          mul_b_q <= u_b;
          mul_start_q <= (cv_q != CV_LIN);
          state_q <= (cv_q == CV_LIN) ? S_SCALE : S_EASE_W;
          if (cv_q == CV_LIN) begin
            f_q <= u_q;
          end
          unique case (cv_q)
            CV_OUT: mul_b_q <= TWO_B - u_b;
            CV_BOTH: begin
              half_q <= 1'b1;
              if (u_q < HALF_T) begin
                mul_a_q <= VW'(u2_b);
                mul_b_q <= u2_b;
              end else begin
                mul_a_q <= VW'(u2_b - ONE_B);
                mul_b_q <= THR_B - u2_b;
                addh_q  <= 1'b1;
              end
            end
            default: ;
          endcase
        end

        S_EASE_W: begin
          if (mul_done) begin
            f_q <= (half_q ? TW'(mul_p >> (F + 1)) : TW'(mul_p >> F))
                   + (addh_q ? HALF_T : TW'(0));
            state_q <= S_SCALE;
          end
        end

        S_SCALE: begin
          mul_a_q     <= x_q;
          mul_b_q     <= BW'(f_q);
          mul_start_q <= 1'b1;
          state_q     <= S_SCALE_W;
        end

        S_SCALE_W: begin
          if (mul_done) begin
            res_q   <= neg_q ? base_q - sc_r : base_q + sc_r;
            state_q <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (kind_q == KIND_SET) begin
              delay_q <= dly_in_q;
              set_q   <= frame_q;
              if (span_in_q == 16'd0) begin
                start_q     <= opv_q;
                target_q    <= opv_q;
                end_q       <= frame_q;
                out_value_q <= opv_q;
                out_done_q  <= 1'b1;
                out_rem_q   <= '0;
              end else begin
                start_q     <= sat32(64'(res_q));
                target_q    <= opv_q;
                end_q       <= frame_q + 32'(span_in_q);
                out_value_q <= sat32(64'(res_q));
                out_done_q  <= 1'b0;
                out_rem_q   <= span_in_q;
              end
            end else begin
              out_value_q <= sat32(64'(res_q));
              out_done_q  <= reach_w;
              if (reach_w) begin
                out_rem_q <= '0;
              end else if (rem_w > 32'(REMAIN_MAX)) begin
                out_rem_q <= REMAIN_MAX;
              end else begin
                out_rem_q <= rem_w[15:0];
              end
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign current_value_o   = $signed(out_value_q);
  assign done_res_o        = out_done_q;
  assign remaining_ticks_o = out_rem_q;

  // a finished result never claims ticks left
  a_done_no_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> remaining_ticks_o == 16'd0)
    else $error("done result with remaining ticks");

  // the divider is never started on a zero divisor
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> div_den_q != '0)
    else $error("divide by zero");

  // t is a clamped fraction
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CURVE |-> t_q <= ONE_T)
    else $error("t above one");

  // shaped curve factor stays within 0..1
  a_f_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE |-> f_q <= ONE_T)
    else $error("curve factor above one");

  // the shared multiplier finishes only while its result is awaited
  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_EASE_W || state_q == S_SCALE_W)
    else $error("stray multiplier result");

endmodule

FILE: src/eva_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eva_mul
// Shift-add multiplier: signed A times unsigned B, one bit of B per cycle.
// ----------------------------------------------------------------------------
module eva_mul #(
  parameter int AW = 52,
  parameter int BW = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [BW-1:0]        b_i,
  output logic                 done_o,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic signed [PW-1:0] acc_q, sh_q;
  logic [BW-1:0]        b_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      sh_q   <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      acc_q  <= '0;
      sh_q   <= PW'(a_i);
      b_q    <= b_i;
      cnt_q  <= CW'(BW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + sh_q;
      end
      sh_q  <= sh_q <<< 1;
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

FILE: src/eva_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eva_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eva_div #(
  parameter int NW = 50,
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quo_q  <= num_i;
      cnt_q  <= CW'(NW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quo_q <= {quo_q[NW-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: bench/eased_value_animator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_value_animator_tb
// Self-checking bench for the eased value animator. A scoreboard runs its own
// model of the animation state and curves, predicts one result per request
// and checks the results in order. Directed requests come first, then random
// phases under every curve style and several spring settings. The sender
// bursts, the receiver stalls and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module eased_value_animator_tb;
  import eva_pkg::*;

  localparam int  FB       = 16;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam int  N_RANDOM = 1550;
  localparam int  N_PHASES = 8;
  localparam int  SETTLE   = 300;          // > slowest request (bounce)
  localparam longint LIMIT = 64'd4_000_000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               done;
    logic [15:0]        remain;
  } anim_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the animator state, expected results in order.
  // --------------------------------------------------------------------------
  class anim_scoreboard;
    bit [2:0]  style;
    bit [15:0] spring;
    bit [31:0] start_v, target_v, frame_t, set_t, end_t, paused_t;
    bit [15:0] delay_t;
    bit        paused;
    anim_result_t expected_q[$];
    int unsigned  n_checked, n_errors;

    function new();
      style = STYLE_LINEAR; spring = SPRING_DEFAULT;
      start_v = 0; target_v = 0; frame_t = 0; set_t = 0; end_t = 0;
      paused_t = 0; delay_t = 0; paused = 0;
      n_checked = 0; n_errors = 0;
    endfunction

    function longint sx(bit [31:0] x);
      return longint'(signed'(x));
    endfunction

    function bit [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // floor(x * f / ONE) for f >= 0
    function longint scale_by(longint x, longint f);
      longint hi, lo;
      hi = x >>> FB;
      lo = x - hi * ONE_Q;
      return hi * f + ((lo * f) >>> FB);
    endfunction

    function longint curve_in(longint t);
      return (t * t) >>> FB;
    endfunction

    function longint curve_out(longint t);
      return (t * (2 * ONE_Q - t)) >>> FB;
    endfunction

    function longint curve_both(longint t);
      if (t < ONE_Q / 2) return curve_in(2 * t) >>> 1;
      return ONE_Q / 2 + (curve_out(2 * t - ONE_Q) >>> 1);
    endfunction

    function bit has_reached(bit [31:0] now);
      return sx(now - end_t) >= 0;
    endfunction

    function longint value_at(bit [31:0] now);
      longint span, s0, tg, delta, elapsed, t, s, b1, b2, pd, t3, sp;
      span = sx(end_t - set_t);
      s0 = sx(start_v);
      tg = sx(target_v);
      delta = tg - s0;
      if (has_reached(now) || span <= 0) return tg;
      span -= longint'(delay_t);
      elapsed = sx(now - set_t) - longint'(delay_t);
      if (span <= 0 || elapsed <= 0) t = 0;
      else if (elapsed >= span) t = ONE_Q;
      else t = (elapsed <<< FB) / span;
      case (style)
        STYLE_IN:   return s0 + scale_by(delta, curve_in(t));
        STYLE_OUT:  return s0 + scale_by(delta, curve_out(t));
        STYLE_BOTH: return s0 + scale_by(delta, curve_both(t));
        STYLE_BOUNCE, STYLE_FBOUNCE: begin
          s = (spring != 0) ? longint'(spring) : longint'(SPRING_DEFAULT);
          t3 = 3 * t;
          if (style == STYLE_BOUNCE) begin
            b1 = (delta * 256) / s;
            b2 = (delta * 65536) / (s * s);
          end else begin
            sp = (s <<< FB) >>> 8;
            b1 = delta >= 0 ? sp : -sp;
            b2 = delta >= 0 ? sp / 2 : -(sp / 2);
          end
          pd = delta + b1;
          if (t3 < ONE_Q) return s0 + scale_by(pd, curve_out(t3));
          if (t3 < 2 * ONE_Q) return s0 + pd - scale_by(b1 + b2, curve_both(t3 - ONE_Q));
          return tg - b2 + scale_by(b2, curve_both(t3 - 2 * ONE_Q));
        end
        default:    return s0 + scale_by(delta, t);   // linear, codes 6 and 7
      endcase
    endfunction

    function void resume_clock();
      bit [31:0] d;
      if (!paused) return;
      paused = 0;
      d = frame_t - paused_t;
      set_t += d;
      end_t += d;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] data);
      if (idx == CFG_STYLE) style = data[2:0];
      else if (idx == CFG_SPRING) spring = data;
    endfunction

    // apply one accepted request and queue the result it must produce
    function void note_request(bit [2:0] kind, bit [31:0] opv, bit [15:0] span,
                               bit [15:0] delay);
      bit [31:0] now, rem;
      anim_result_t r;
      case (kind)
        KIND_TICK: frame_t += 1;
        KIND_SET: begin
          resume_clock();
          if (span == 0) begin
            start_v = opv; target_v = opv; set_t = frame_t; end_t = frame_t;
          end else begin
            start_v = clamp32(value_at(frame_t));
            target_v = opv; set_t = frame_t; end_t = frame_t + span;
          end
          delay_t = delay;
        end
        KIND_SHIFT: begin
          start_v  = clamp32(sx(start_v) + sx(opv));
          target_v = clamp32(sx(target_v) + sx(opv));
        end
        KIND_ADJUST: target_v = opv;
        KIND_PAUSE: if (!paused && !has_reached(frame_t)) begin
          paused_t = frame_t;
          paused = 1;
        end
        KIND_RESUME: resume_clock();
        default: ;                                  // unused kinds only report
      endcase
      now = paused ? paused_t : frame_t;
      r.done = has_reached(now);
      rem = end_t - now;
      r.remain = r.done ? 16'd0 : (rem > 32'hFFFF ? REMAIN_MAX : rem[15:0]);
      r.value = clamp32(value_at(now));
      expected_q.push_back(r);
    endfunction

    function void check_result(anim_result_t got);
      anim_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: value %0d", got.value);
        n_errors++;
        return;
      end
      exp = expected_q.pop_front();
      n_checked++;
      if (got.value !== exp.value) begin
        $error("current_value: expected %0d, got %0d", exp.value, got.value);
        n_errors++;
      end
      if (got.done !== exp.done) begin
        $error("done_res: expected %0d, got %0d", exp.done, got.done);
        n_errors++;
      end
      if (got.remain !== exp.remain) begin
        $error("remaining_ticks: expected %0d, got %0d", exp.remain, got.remain);
        n_errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [2:0]  kind;
  logic signed [31:0] operand;
  logic [15:0] span, delay;
  logic signed [31:0] cur_value;
  logic        done_flag;
  logic [15:0] remain;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  anim_scoreboard sb = new();
  longint cycles = 0;
  int unsigned n_requests = 0;
  int unsigned burst_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  eased_value_animator u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .operand_value_i(operand),
    .span_ticks_i(span), .delay_ticks_i(delay),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .current_value_o(cur_value), .done_res_o(done_flag),
    .remaining_ticks_o(remain),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("eased_value_animator_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall pattern, one long hold-off once traffic is flowing.
  // Results are sampled on the edge, before any NBA of this step lands.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode_left, hold;
    int unsigned ready_pct;
    bit held;
    anim_result_t got;
    mode_left = 0; ready_pct = 100; held = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.value = cur_value; got.done = done_flag; got.remain = remain;
        sb.check_result(got);
      end
      if (!held && sb.n_checked >= 300) begin
        // long hold-off: the sender keeps offering, the block backs up
        held = 1;
        out_ready <= 0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        out_ready <= 1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(5, 80);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;              // no stalls
            1: ready_pct = 70;
            2: ready_pct = 30;
            default: ready_pct = 5;
          endcase
        end
        mode_left--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] k, input logic [31:0] opv,
                              input logic [15:0] sp, input logic [15:0] dl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1;
    kind <= k; operand <= opv; span <= sp; delay <= dl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(k, opv, sp, dl);
    n_requests++;
  endtask

  task automatic drain_idle();
    in_valid <= 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 19))
      0:  return 32'h7FFF_FFFF;
      1:  return 32'h8000_0000;
      2:  return 32'h0000_0000;
      3, 4, 5, 6, 7, 8: return $urandom();
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic random_request();
    logic [15:0] sp, dl;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_request(KIND_TICK, $urandom(), $urandom(), $urandom());
    end else if (pick < 66) begin
      case ($urandom_range(0, 9))
        0: sp = 0;
        1: sp = $urandom_range(0, 16'hFFFF);
        default: sp = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 6))
        0: dl = 0;
        1: dl = $urandom_range(0, 16'hFFFF);
        2: dl = sp + $urandom_range(0, 4);   // delay covering the span
        default: dl = $urandom_range(0, sp);
      endcase
      send_request(KIND_SET, pick_operand(), sp, dl);
    end else if (pick < 74) begin
      send_request(KIND_SHIFT, pick_operand(), $urandom(), $urandom());
    end else if (pick < 81) begin
      send_request(KIND_ADJUST, pick_operand(), $urandom(), $urandom());
    end else if (pick < 89) begin
      send_request(KIND_PAUSE, $urandom(), $urandom(), $urandom());
    end else if (pick < 97) begin
      send_request(KIND_RESUME, $urandom(), $urandom(), $urandom());
    end else begin
      send_request(3'($urandom_range(6, 7)), $urandom(), $urandom(), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int i, p;
    in_valid = 0; kind = KIND_TICK; operand = 0; span = 0; delay = 0;
    cfg_valid = 0; cfg_index = CFG_STYLE; cfg_data = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fixed bounce with widest spring, then extremes of every kind
    write_reg(CFG_STYLE, 16'(STYLE_FBOUNCE));
    write_reg(CFG_SPRING, 16'hFFFF);
    send_request(KIND_TICK, 0, 0, 0);
    send_request(KIND_SET, 32'h7FFF_FFFF, 16'd0, 16'd0);        // jump
    send_request(KIND_SET, 32'h8000_0000, 16'd9, 16'd2);        // full swing
    for (i = 0; i < 4; i++) send_request(KIND_TICK, 0, 0, 0);
    send_request(KIND_PAUSE, 0, 0, 0);
    send_request(KIND_PAUSE, 0, 0, 0);                          // already paused
    send_request(KIND_TICK, 0, 0, 0);
    send_request(KIND_RESUME, 0, 0, 0);
    send_request(KIND_RESUME, 0, 0, 0);                         // already running
    send_request(KIND_SHIFT, 32'h8000_0000, 0, 0);              // saturates low
    send_request(KIND_SHIFT, 32'h7FFF_FFFF, 0, 0);
    send_request(KIND_ADJUST, 32'h0001_0000, 0, 0);
    send_request(KIND_SET, 32'h0010_0000, 16'd5, 16'd7);        // delay past span
    send_request(KIND_TICK, 0, 0, 0);
    send_request(KIND_SET, 32'hFFF0_0000, 16'hFFFF, 16'hFFFF);  // remaining at its maximum
    send_request(KIND_PAUSE, 0, 0, 0);
    send_request(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(3'd7, 0, 0, 0);
    send_request(KIND_SET, 32'h0000_0001, 16'd0, 16'd0);        // pause on done: ignored
    send_request(KIND_PAUSE, 0, 0, 0);
    drain_idle();

    // random phases, each under a new curve and spring
    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_reg(CFG_STYLE, 16'(STYLE_LINEAR));
        1: write_reg(CFG_STYLE, 16'(STYLE_IN));
        2: write_reg(CFG_STYLE, 16'(STYLE_OUT));
        3: write_reg(CFG_STYLE, 16'(STYLE_BOTH));
        4, 6: write_reg(CFG_STYLE, 16'(STYLE_BOUNCE));
        5: write_reg(CFG_STYLE, 16'(STYLE_FBOUNCE));
        default: write_reg(CFG_STYLE, 16'($urandom_range(0, 7)));
      endcase
      case (p % 4)
        0: write_reg(CFG_SPRING, 16'd0);        // zero falls back to 3.0
        1: write_reg(CFG_SPRING, 16'd1);
        2: write_reg(CFG_SPRING, 16'hFFFF);
        default: write_reg(CFG_SPRING, 16'($urandom()));
      endcase
      for (i = 0; i < N_RANDOM / N_PHASES; i++) random_request();
      drain_idle();
    end

    $display("covered %0d requests, %0d results checked, %0d phases of curve/spring",
             n_requests, sb.n_checked, N_PHASES + 1);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("eased_value_animator_tb OK");
    end else begin
      $display("eased_value_animator_tb NOT OK");
    end
    $finish;
  end

endmodule
